FILE: design/isqp_pkg.sv
// isqp_pkg: shared widths, register codes and structs for the quote pricer
// no dependencies; used by every module in design/
package isqp_pkg;

	localparam int MIN_TICKS_DEF = 1;
	localparam int MAX_TICKS_DEF = 999;
	localparam int FRAC_BITS_DEF = 16;

	localparam int FV_W   = 26;
	localparam int INV_W  = 24;
	localparam int SIG_W  = 16;
	localparam int CFG_W  = 32;
	localparam int LIM_W  = 23;
	localparam int TICK_W = 10;
	localparam int ADDR_W = 4;
	localparam int SQ_W   = 2 * SIG_W;
	localparam int DLT_W  = CFG_W + 1;
	localparam int QV_W   = INV_W + CFG_W + 1;
	localparam int RES_W  = QV_W + 1;

	localparam logic [LIM_W-1:0] LIMIT_RESET = '1;

	typedef enum logic [1:0] {
		REG_RISK   = 2'd0,
		REG_OFFSET = 2'd1,
		REG_MIN    = 2'd2,
		REG_LIMIT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] risk_coeff;
		logic [CFG_W-1:0] spread_offset;
		logic [CFG_W-1:0] spread_floor;
		logic [LIM_W-1:0] inventory_limit;
	} cfg_t;

	// handoff from the arithmetic front end to the quote back end
	typedef struct packed {
		logic                    valid;
		logic                    nz;
		logic signed [INV_W-1:0] q;
		logic signed [RES_W-1:0] r;
		logic [DLT_W-1:0]        delta;
	} arith_out_t;

endpackage

FILE: design/inventory_skewed_quote_pricer_core.sv
// inventory-skewed quote pricer: reservation price, spread, bid/ask ticks
// one word per cycle, busy stays low; six register stages: sigma^2, risk multiply,
// inventory multiply, reservation sum, tick rounding, crossing fix with clamp
// arst_n clears valid bits and config registers, but sets the inventory limit to all ones
// depends on isqp_pkg, isqp_regs, isqp_arith, isqp_quote
module inventory_skewed_quote_pricer_core #(
	parameter int MIN_TICKS = isqp_pkg::MIN_TICKS_DEF,
	parameter int MAX_TICKS = isqp_pkg::MAX_TICKS_DEF,
	parameter int FRAC_BITS = isqp_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command side
	input  logic                                  start,
	output logic                                  busy,
	input  logic [isqp_pkg::FV_W-1:0]             fair_px,
	input  logic signed [isqp_pkg::INV_W-1:0]     inventory,
	input  logic [isqp_pkg::SIG_W-1:0]            sigma,
	// result side, one-cycle strobe
	output logic                                  done,
	output logic                                  valid_res,
	output logic signed [isqp_pkg::CFG_W-1:0]     resv_px,
	output logic [isqp_pkg::CFG_W-1:0]            quote_spread,
	output logic [isqp_pkg::TICK_W-1:0]           bid_px,
	output logic [isqp_pkg::TICK_W-1:0]           ask_px,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [isqp_pkg::ADDR_W-1:0]           paddr,
	input  logic [isqp_pkg::CFG_W-1:0]            pwdata,
	output logic [isqp_pkg::CFG_W-1:0]            prdata,
	output logic                                  pready
);

	isqp_pkg::cfg_t       cfg;
	isqp_pkg::arith_out_t aout;
	logic                 accept;

	// fully pipelined and the receiver never stalls, so a word is taken every cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// register file: risk, offset, min spread, inventory limit
	isqp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stages 1-4: v = (risk * sigma^2) >> 32, r = s - q*v, delta = max(v + offset, min)
	isqp_arith u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.fair_px    (fair_px),
		.inventory  (inventory),
		.sigma      (sigma),
		.cfg        (cfg),
		.aout       (aout)
	);

	// stages 5-6: floor/ceil to ticks, uncross, clamp, side suppression, saturation
	isqp_quote #(
		.MIN_TICKS (MIN_TICKS),
		.MAX_TICKS (MAX_TICKS),
		.FRAC_BITS (FRAC_BITS)
	) u_quote (
		.clk          (clk),
		.arst_n       (arst_n),
		.ain          (aout),
		.cfg          (cfg),
		.done         (done),
		.valid_res    (valid_res),
		.resv_px      (resv_px),
		.quote_spread (quote_spread),
		.bid_px       (bid_px),
		.ask_px       (ask_px)
	);

	// every result word comes from a word taken earlier with start high
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result word without a matching start");

	// a zero fair value gives an all-zero word
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (resv_px == '0 && quote_spread == '0
			&& bid_px == '0 && ask_px == '0))
		else $error("invalid word carries nonzero fields");

	// the spread never falls under the configured minimum
	a_spread_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_res) |-> (quote_spread >= cfg.spread_floor))
		else $error("spread below minimum");

endmodule

FILE: design/isqp_regs.sv
// isqp_regs: apb configuration register file
// depends on isqp_pkg
module isqp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [isqp_pkg::ADDR_W-1:0]   paddr,
	input  logic [isqp_pkg::CFG_W-1:0]    pwdata,
	output logic [isqp_pkg::CFG_W-1:0]    prdata,
	output logic                          pready,
	output isqp_pkg::cfg_t                cfg
);

	isqp_pkg::cfg_t    cfg_q;
	isqp_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = isqp_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.risk_coeff      <= '0;
			cfg_q.spread_offset   <= '0;
			cfg_q.spread_floor    <= '0;
			cfg_q.inventory_limit <= isqp_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				isqp_pkg::REG_RISK:   cfg_q.risk_coeff      <= pwdata;
				isqp_pkg::REG_OFFSET: cfg_q.spread_offset   <= pwdata;
				isqp_pkg::REG_MIN:    cfg_q.spread_floor    <= pwdata;
				isqp_pkg::REG_LIMIT:  cfg_q.inventory_limit <= pwdata[isqp_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			isqp_pkg::REG_RISK:   prdata = cfg_q.risk_coeff;
			isqp_pkg::REG_OFFSET: prdata = cfg_q.spread_offset;
			isqp_pkg::REG_MIN:    prdata = cfg_q.spread_floor;
			isqp_pkg::REG_LIMIT:  prdata = isqp_pkg::CFG_W'(cfg_q.inventory_limit);
			default:              prdata = '0;
		endcase
	end

endmodule

FILE: design/isqp_arith.sv
// isqp_arith: stages 1-4, sigma^2, risk term, inventory skew and spread
// depends on isqp_pkg
module isqp_arith (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [isqp_pkg::FV_W-1:0]          fair_px,
	input  logic signed [isqp_pkg::INV_W-1:0]  inventory,
	input  logic [isqp_pkg::SIG_W-1:0]         sigma,
	input  isqp_pkg::cfg_t                     cfg,
	output isqp_pkg::arith_out_t               aout
);

	localparam int FV_W  = isqp_pkg::FV_W;
	localparam int INV_W = isqp_pkg::INV_W;
	localparam int CFG_W = isqp_pkg::CFG_W;
	localparam int SQ_W  = isqp_pkg::SQ_W;
	localparam int DLT_W = isqp_pkg::DLT_W;
	localparam int QV_W  = isqp_pkg::QV_W;
	localparam int RES_W = isqp_pkg::RES_W;

	logic [3:0] valid_s, nz_s;

	logic [SQ_W-1:0]          sigsq_s1;
	logic [FV_W-1:0]          fv_s1, fv_s2, fv_s3;
	logic signed [INV_W-1:0]  q_s1, q_s2, q_s3, q_s4;
	logic [CFG_W-1:0]         v_s2;
	logic signed [QV_W-1:0]   qv_s3;
	logic [DLT_W-1:0]         delta_s3, delta_s4;
	logic signed [RES_W-1:0]  r_s4;

	logic [2*CFG_W-1:0]       prod_c;
	logic signed [QV_W-1:0]   qv_c;
	logic [DLT_W-1:0]         sum_c, delta_c;

	assign prod_c  = cfg.risk_coeff * sigsq_s1;
	assign qv_c    = q_s2 * $signed({1'b0, v_s2});
	assign sum_c   = {1'b0, v_s2} + {1'b0, cfg.spread_offset};
	assign delta_c = (sum_c < {1'b0, cfg.spread_floor}) ? {1'b0, cfg.spread_floor} : sum_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
			nz_s    <= '0;
		end else begin
			valid_s <= {valid_s[2:0], in_valid};
			nz_s    <= {nz_s[2:0], (fair_px != '0)};
		end
	end

	always_ff @(posedge clk) begin
		sigsq_s1 <= sigma * sigma;
		fv_s1    <= fair_px;
		q_s1     <= inventory;

		v_s2     <= prod_c[2*CFG_W-1:CFG_W];
		fv_s2    <= fv_s1;
		q_s2     <= q_s1;

		qv_s3    <= qv_c;
		delta_s3 <= delta_c;
		fv_s3    <= fv_s2;
		q_s3     <= q_s2;

		r_s4     <= $signed({{(RES_W-FV_W){1'b0}}, fv_s3}) - RES_W'(qv_s3);
		delta_s4 <= delta_s3;
		q_s4     <= q_s3;
	end

	assign aout.valid = valid_s[3];
	assign aout.nz    = nz_s[3];
	assign aout.q     = q_s4;
	assign aout.r     = r_s4;
	assign aout.delta = delta_s4;

endmodule

FILE: design/isqp_quote.sv
// isqp_quote: stages 5-6, tick rounding, crossing fix, clamp and suppression
// depends on isqp_pkg
module isqp_quote #(
	parameter int MIN_TICKS = isqp_pkg::MIN_TICKS_DEF,
	parameter int MAX_TICKS = isqp_pkg::MAX_TICKS_DEF,
	parameter int FRAC_BITS = isqp_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  isqp_pkg::arith_out_t                  ain,
	input  isqp_pkg::cfg_t                        cfg,
	output logic                                  done,
	output logic                                  valid_res,
	output logic signed [isqp_pkg::CFG_W-1:0]     resv_px,
	output logic [isqp_pkg::CFG_W-1:0]            quote_spread,
	output logic [isqp_pkg::TICK_W-1:0]           bid_px,
	output logic [isqp_pkg::TICK_W-1:0]           ask_px
);

	localparam int CFG_W  = isqp_pkg::CFG_W;
	localparam int INV_W  = isqp_pkg::INV_W;
	localparam int LIM_W  = isqp_pkg::LIM_W;
	localparam int DLT_W  = isqp_pkg::DLT_W;
	localparam int RES_W  = isqp_pkg::RES_W;
	localparam int TICK_W = isqp_pkg::TICK_W;
	localparam int NW     = RES_W + 2;
	localparam int SH     = FRAC_BITS + 1;

	localparam logic signed [NW-1:0] RND   = NW'((64'd1 << SH) - 64'd1);
	localparam logic signed [NW-1:0] MIN_T = NW'(MIN_TICKS);
	localparam logic signed [NW-1:0] MAX_T = NW'(MAX_TICKS);

	// stage 5
	logic                     valid_s5, nz_s5;
	logic signed [NW-1:0]     bid_s5, ask_s5;
	logic signed [INV_W-1:0]  q_s5;
	logic [CFG_W-1:0]         rsat_s5, dsat_s5;

	logic signed [NW-1:0]     two_r_c, dext_c, bidn_c, askn_c;
	logic                     fits_c;
	logic [CFG_W-1:0]         rsat_c;

	assign two_r_c = NW'(ain.r) <<< 1;
	assign dext_c  = $signed({{(NW-DLT_W){1'b0}}, ain.delta});
	assign bidn_c  = two_r_c - dext_c;
	assign askn_c  = two_r_c + dext_c + RND;
	assign fits_c  = (ain.r[RES_W-1:CFG_W-1] == '0) || (ain.r[RES_W-1:CFG_W-1] == '1);

	always_comb begin
		if (fits_c) begin
			rsat_c = ain.r[CFG_W-1:0];
		end else if (ain.r[RES_W-1]) begin
			rsat_c = {1'b1, {(CFG_W-1){1'b0}}};
		end else begin
			rsat_c = {1'b0, {(CFG_W-1){1'b1}}};
		end
	end

	// stage 6
	logic                     valid_s6, nz_s6;
	logic signed [NW-1:0]     ask_adj_c, bid_cl_c, ask_cl_c;
	logic signed [INV_W:0]    q_ext_c, lim_ext_c;
	logic [TICK_W-1:0]        bid_c, ask_c;
	logic [CFG_W-1:0]         rp_s6, sp_s6;
	logic [TICK_W-1:0]        bid_s6, ask_s6;

	assign q_ext_c   = {q_s5[INV_W-1], q_s5};
	assign lim_ext_c = $signed({{(INV_W+1-LIM_W){1'b0}}, cfg.inventory_limit});

	always_comb begin
		ask_adj_c = (ask_s5 <= bid_s5) ? bid_s5 + NW'(1) : ask_s5;

		bid_cl_c = (bid_s5 < MIN_T) ? MIN_T : bid_s5;
		if (bid_cl_c > MAX_T) begin
			bid_cl_c = MAX_T;
		end
		ask_cl_c = (ask_adj_c < MIN_T) ? MIN_T : ask_adj_c;
		if (ask_cl_c > MAX_T) begin
			ask_cl_c = MAX_T;
		end

		bid_c = bid_cl_c[TICK_W-1:0];
		ask_c = ask_cl_c[TICK_W-1:0];
		// long beyond the limit: stop buying; short beyond it: stop selling
		if (q_ext_c > lim_ext_c) begin
			bid_c = '0;
		end else if (q_ext_c < -lim_ext_c) begin
			ask_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= ain.valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		nz_s5   <= ain.nz;
		q_s5    <= ain.q;
		bid_s5  <= bidn_c >>> SH;
		ask_s5  <= askn_c >>> SH;
		rsat_s5 <= rsat_c;
		dsat_s5 <= ain.delta[DLT_W-1] ? '1 : ain.delta[CFG_W-1:0];

		nz_s6   <= nz_s5;
		rp_s6   <= nz_s5 ? rsat_s5 : '0;
		sp_s6   <= nz_s5 ? dsat_s5 : '0;
		bid_s6  <= nz_s5 ? bid_c : '0;
		ask_s6  <= nz_s5 ? ask_c : '0;
	end

	assign done         = valid_s6;
	assign valid_res    = nz_s6;
	assign resv_px      = $signed(rp_s6);
	assign quote_spread = sp_s6;
	assign bid_px       = bid_s6;
	assign ask_px       = ask_s6;

endmodule

FILE: tb/sv/tb_inventory_skewed_quote_pricer_core.sv
// testbench for inventory_skewed_quote_pricer_core: directed table, then random quote words
// under several register settings, each word checked against a typed answer or a behavioral price predictor
// depends on isqp_pkg and design/inventory_skewed_quote_pricer_core.sv
module tb_inventory_skewed_quote_pricer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FV_W   = isqp_pkg::FV_W;
	localparam int INV_W  = isqp_pkg::INV_W;
	localparam int SIG_W  = isqp_pkg::SIG_W;
	localparam int CFG_W  = isqp_pkg::CFG_W;
	localparam int LIM_W  = isqp_pkg::LIM_W;
	localparam int TICK_W = isqp_pkg::TICK_W;
	localparam int ADDR_W = isqp_pkg::ADDR_W;

	localparam int MIN_T = 1;
	localparam int MAX_T = 999;
	localparam int FRAC = 16;
	localparam int PIPE_DEPTH = 6;
	localparam int NUM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 245;
	localparam int MAX_REPORTS = 10;

	// one quote word as it leaves the block
	typedef struct packed {
		logic                    valid;
		logic signed [CFG_W-1:0] rp;
		logic [CFG_W-1:0]        spread;
		logic [TICK_W-1:0]       bid;
		logic [TICK_W-1:0]       ask;
	} quote_t;

	typedef enum logic [1:0] {
		STEP_WRITE,
		STEP_QUOTE,
		STEP_TYPED
	} step_kind_t;

	// directed row: a register write, a predicted quote, or a quote with its answer typed in
	typedef struct packed {
		step_kind_t              kind;
		isqp_pkg::reg_idx_t      idx;
		logic [CFG_W-1:0]        wdata;
		logic [FV_W-1:0]         fv;
		logic signed [INV_W-1:0] inv;
		logic [SIG_W-1:0]        sig;
		quote_t                  answer;
	} step_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [FV_W-1:0]         fair_px;
	logic signed [INV_W-1:0] inventory;
	logic [SIG_W-1:0]        sigma;
	logic                    done;
	logic                    valid_res;
	logic signed [CFG_W-1:0] resv_px;
	logic [CFG_W-1:0]        quote_spread;
	logic [TICK_W-1:0]       bid_px;
	logic [TICK_W-1:0]       ask_px;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [CFG_W-1:0]        pwdata;
	logic [CFG_W-1:0]        prdata;
	logic                    pready;

	// shadow copy of the configuration registers
	logic [CFG_W-1:0] cfg_risk;
	logic [CFG_W-1:0] cfg_offset;
	logic [CFG_W-1:0] cfg_min;
	logic [LIM_W-1:0] cfg_limit;

	quote_t pending_quotes[$];
	step_t  directed_steps[$];
	int     mismatch_cnt = 0;
	int     words_sent = 0;
	int     words_checked = 0;
	int     reg_writes = 0;
	bit     idle_on = 1'b0;

	inventory_skewed_quote_pricer_core #(
		.MIN_TICKS(MIN_T),
		.MAX_TICKS(MAX_T),
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.fair_px(fair_px),
		.inventory(inventory),
		.sigma(sigma),
		.done(done),
		.valid_res(valid_res),
		.resv_px(resv_px),
		.quote_spread(quote_spread),
		.bid_px(bid_px),
		.ask_px(ask_px),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// quote price predictor, exact integer math at 64 bits
	function automatic quote_t price_quote(logic [FV_W-1:0] fv, logic signed [INV_W-1:0] inv,
			logic [SIG_W-1:0] sig);
		quote_t      qt;
		longint      q;
		longint      r;
		longint      b;
		longint      a;
		logic [63:0] sq;
		logic [63:0] v;
		logic [63:0] delta;
		qt = '0;
		if (fv == 0) begin
			return qt;
		end
		q = longint'(inv);
		sq = 64'(sig) * 64'(sig);
		// risk term keeps FRAC fraction bits after dropping the Q0.32 of sigma^2
		v = (64'(cfg_risk) * sq) >> 32;
		r = longint'(64'(fv)) - q * longint'(v);
		delta = v + 64'(cfg_offset);
		if (delta < 64'(cfg_min)) begin
			delta = 64'(cfg_min);
		end
		// arithmetic shift of a signed value is floor division by a power of two
		b = (2 * r - longint'(delta)) >>> (FRAC + 1);
		a = -((-(2 * r + longint'(delta))) >>> (FRAC + 1));
		if (a - b < 1) begin
			a = b + 1;
		end
		if (b < MIN_T) b = MIN_T;
		if (b > MAX_T) b = MAX_T;
		if (a < MIN_T) a = MIN_T;
		if (a > MAX_T) a = MAX_T;
		// one side drops out once the position passes the limit
		if (q > longint'(64'(cfg_limit))) begin
			b = 0;
		end else if (q < -longint'(64'(cfg_limit))) begin
			a = 0;
		end
		qt.valid = 1'b1;
		if (r > 64'sd2147483647) begin
			qt.rp = 32'h7FFF_FFFF;
		end else if (r < -64'sd2147483648) begin
			qt.rp = 32'h8000_0000;
		end else begin
			qt.rp = r[31:0];
		end
		qt.spread = (delta > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : delta[31:0];
		qt.bid = b[TICK_W-1:0];
		qt.ask = a[TICK_W-1:0];
		return qt;
	endfunction

	task automatic flag_mismatch(input string what, input logic [CFG_W-1:0] want,
			input logic [CFG_W-1:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS) begin
			$display("%0t: %s mismatch, expected 0x%08h got 0x%08h", $realtime, what, want, got);
		end
	endtask

	// result side: every done strobe is matched against the oldest pending quote
	always @(posedge clk) begin
		quote_t want;
		if (arst_n && done) begin
			if (pending_quotes.size() == 0) begin
				flag_mismatch("unexpected word", 32'd0, 32'd1);
			end else begin
				want = pending_quotes.pop_front();
				words_checked++;
				if (valid_res !== want.valid)
					flag_mismatch("valid_res", 32'(want.valid), 32'(valid_res));
				if (resv_px !== want.rp)
					flag_mismatch("resv_px", want.rp, resv_px);
				if (quote_spread !== want.spread)
					flag_mismatch("quote_spread", want.spread, quote_spread);
				if (bid_px !== want.bid)
					flag_mismatch("bid_px", 32'(want.bid), 32'(bid_px));
				if (ask_px !== want.ask)
					flag_mismatch("ask_px", 32'(want.ask), 32'(ask_px));
			end
		end
	end

	// drive one quote word, after a random idle gap while gaps are on; the prediction is taken at the accept edge
	task automatic issue_quote(input logic [FV_W-1:0] fv, input logic signed [INV_W-1:0] inv,
			input logic [SIG_W-1:0] sig, input bit typed, input quote_t answer);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		fair_px <= fv;
		inventory <= inv;
		sigma <= sig;
		do @(posedge clk); while (busy);
		pending_quotes.push_back(typed ? answer : price_quote(fv, inv, sig));
		words_sent++;
	endtask

	// let the pipe run dry before touching a register
	task automatic settle_pipe();
		@(negedge clk);
		start <= 1'b0;
		while (pending_quotes.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// apb write, then read the register back
	task automatic write_reg(input isqp_pkg::reg_idx_t idx, input logic [CFG_W-1:0] val);
		logic [CFG_W-1:0] got;
		logic [CFG_W-1:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			isqp_pkg::REG_RISK:   cfg_risk = val;
			isqp_pkg::REG_OFFSET: cfg_offset = val;
			isqp_pkg::REG_MIN:    cfg_min = val;
			isqp_pkg::REG_LIMIT:  cfg_limit = val[LIM_W-1:0];
			default:    ;
		endcase
		reg_writes++;
		// read setup on the same address
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		want = (idx == isqp_pkg::REG_LIMIT) ? 32'(val[LIM_W-1:0]) : val;
		if (got !== want) begin
			flag_mismatch("register readback", want, got);
		end
	endtask

	initial begin
		int             w;
		int             inv_i;
		logic [FV_W-1:0]  fv;
		logic [SIG_W-1:0] sig;
		logic signed [INV_W-1:0] inv;
		// every input known from time zero
		arst_n = 1'b0;
		start = 1'b0;
		fair_px = '0;
		inventory = '0;
		sigma = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_risk = '0;
		cfg_offset = '0;
		cfg_min = '0;
		cfg_limit = isqp_pkg::LIMIT_RESET;

		// directed rows; the first ones run on the reset settings where the answer is plain
		// zero fair value: everything zero
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd0, 24'sd123,
			16'hFFFF, '{1'b0, 32'sd0, 32'd0, 10'd0, 10'd0}});
		// smallest price: bid floors to zero then clamps up to the lowest tick
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd1, 24'sd0, 16'd0,
			'{1'b1, 32'sd1, 32'd0, 10'd1, 10'd1}});
		// top of every field, both sides clamp to the highest tick
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'h3FF_FFFF,
			24'sh7FFFFF, 16'hFFFF, '{1'b1, 32'sd67108863, 32'd0, 10'd999, 10'd999}});
		// whole-tick price with zero spread: ask pushed one tick above the bid
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd6553600, 24'sd0,
			16'd0, '{1'b1, 32'sd6553600, 32'd0, 10'd100, 10'd101}});
		// most negative position is beyond the reset limit: ask suppressed
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd32768000,
			24'sh800000, 16'd0, '{1'b1, 32'sd32768000, 32'd0, 10'd500, 10'd0}});
		// half-tick price splits cleanly
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd98304, 24'sd0,
			16'd0, '{1'b1, 32'sd98304, 32'd0, 10'd1, 10'd2}});
		// zero limit: any long position kills the bid, any short kills the ask
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_LIMIT, 32'd0, 26'd0, 24'sd0, 16'd0,
			'0});
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd19660800, 24'sd1,
			16'h1234, '{1'b1, 32'sd19660800, 32'd0, 10'd0, 10'd301}});
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd19660800,
			-24'sd1, 16'h1234, '{1'b1, 32'sd19660800, 32'd0, 10'd300, 10'd0}});
		directed_steps.push_back('{STEP_TYPED, isqp_pkg::REG_RISK, 32'd0, 26'd19660800, 24'sd0,
			16'h1234, '{1'b1, 32'sd19660800, 32'd0, 10'd300, 10'd301}});
		// widest minimum spread: bid pinned low, ask pinned high
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_MIN, 32'hFFFF_FFFF, 26'd0, 24'sd0,
			16'd0, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd32768000, 24'sd0,
			16'd0, '0});
		// risk and offset at their top, minimum and limit at zero: reservation and spread saturate
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_MIN, 32'd0, 26'd0, 24'sd0, 16'd0,
			'0});
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_OFFSET, 32'hFFFF_FFFF, 26'd0,
			24'sd0, 16'd0, '0});
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_RISK, 32'hFFFF_FFFF, 26'd0, 24'sd0,
			16'd0, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'h3FF_FFFF,
			24'sh7FFFFF, 16'hFFFF, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'h3FF_FFFF,
			24'sh800000, 16'hFFFF, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd1, 24'sd0, 16'd1,
			'0});
		// moderate settings: one tick of risk per unit of position at sigma one half
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_RISK, 32'h0004_0000, 26'd0, 24'sd0,
			16'd0, '0});
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_OFFSET, 32'h0002_0000, 26'd0,
			24'sd0, 16'd0, '0});
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_MIN, 32'h0003_0000, 26'd0, 24'sd0,
			16'd0, '0});
		directed_steps.push_back('{STEP_WRITE, isqp_pkg::REG_LIMIT, 32'd100, 26'd0, 24'sd0,
			16'd0, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd26214400,
			24'sd50, 16'h8000, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd26214400,
			-24'sd50, 16'h8000, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd26214400,
			24'sd101, 16'h8000, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd26214400,
			-24'sd101, 16'h8000, '0});
		directed_steps.push_back('{STEP_QUOTE, isqp_pkg::REG_RISK, 32'd0, 26'd26214400,
			24'sd0, 16'hFFFF, '0});

		// reset held from time zero, released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, back to back
		foreach (directed_steps[i]) begin
			case (directed_steps[i].kind)
				STEP_WRITE: begin
					settle_pipe();
					write_reg(directed_steps[i].idx, directed_steps[i].wdata);
				end
				STEP_TYPED: issue_quote(directed_steps[i].fv, directed_steps[i].inv,
					directed_steps[i].sig, 1'b1, directed_steps[i].answer);
				default: issue_quote(directed_steps[i].fv, directed_steps[i].inv,
					directed_steps[i].sig, 1'b0, '0);
			endcase
		end

		// random part: each phase picks a register setting, then streams quote words
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_pipe();
			if (p == 0) begin
				// everything at the bottom, zero limit
				write_reg(isqp_pkg::REG_RISK, 32'd0);
				write_reg(isqp_pkg::REG_OFFSET, 32'd0);
				write_reg(isqp_pkg::REG_MIN, 32'd0);
				write_reg(isqp_pkg::REG_LIMIT, 32'd0);
			end else if (p == 1) begin
				// everything at the top
				write_reg(isqp_pkg::REG_RISK, 32'hFFFF_FFFF);
				write_reg(isqp_pkg::REG_OFFSET, 32'hFFFF_FFFF);
				write_reg(isqp_pkg::REG_MIN, 32'hFFFF_FFFF);
				write_reg(isqp_pkg::REG_LIMIT, 32'(isqp_pkg::LIMIT_RESET));
			end else begin
				// mostly settings that keep quotes inside the tick range, some wild ones
				case ($urandom_range(0, 3))
					0: write_reg(isqp_pkg::REG_RISK, $urandom_range(0, 32'h0004_0000));
					1: write_reg(isqp_pkg::REG_RISK, $urandom_range(0, 32'h0040_0000));
					2: write_reg(isqp_pkg::REG_RISK, $urandom);
					default: write_reg(isqp_pkg::REG_RISK, 32'd0);
				endcase
				write_reg(isqp_pkg::REG_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom :
					$urandom_range(0, 32'h0008_0000));
				write_reg(isqp_pkg::REG_MIN, ($urandom_range(0, 3) == 0) ? $urandom :
					$urandom_range(0, 32'h000C_0000));
				case ($urandom_range(0, 2))
					0: write_reg(isqp_pkg::REG_LIMIT, $urandom_range(0, 300));
					1: write_reg(isqp_pkg::REG_LIMIT, 32'(isqp_pkg::LIMIT_RESET));
					default: write_reg(isqp_pkg::REG_LIMIT, $urandom);
				endcase
			end
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// idle gaps come and go in stretches of fifty words
				if (n % 50 == 0) begin
					idle_on = ($urandom_range(0, 2) != 0);
				end
				case ($urandom_range(0, 19))
					0: fv = '0;
					1, 2: fv = FV_W'($urandom);
					default: fv = FV_W'($urandom_range(32'h0001_0000, 32'h03E8_0000));
				endcase
				// positions mostly within the limit plus twenty either side (at most 420) so both suppression sides can fire
				if ($urandom_range(0, 3) != 0) begin
					w = (cfg_limit > 400) ? 400 : int'(cfg_limit) + 20;
					inv_i = int'($urandom_range(0, 2 * w)) - w;
					inv = inv_i[INV_W-1:0];
				end else begin
					inv = INV_W'($urandom);
				end
				case ($urandom_range(0, 15))
					0: sig = '0;
					1: sig = '1;
					default: sig = SIG_W'($urandom);
				endcase
				issue_quote(fv, inv, sig, 1'b0, '0);
			end
		end

		// drain the pipe so that any stray word shows before the summary
		settle_pipe();
		$display("run covered %0d quote words (%0d checked) across %0d register writes",
			words_sent, words_checked, reg_writes);
		$display("%0d mismatches, %0d predictions left over", mismatch_cnt, pending_quotes.size());
		if (mismatch_cnt == 0 && pending_quotes.size() == 0) begin
			$display("inventory_skewed_quote_pricer_core test passed");
		end else begin
			$display("inventory_skewed_quote_pricer_core test failed");
		end
		$finish;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("timeout with %0d predictions pending", pending_quotes.size());
		$display("inventory_skewed_quote_pricer_core test failed");
		$finish;
	end

endmodule
